### rtl/core/pwfc_pkg.sv
package pwfc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int RUN_W       = 8;
    localparam int TICKS_W     = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MIN        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MIN         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOO_LONG_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH_TICKS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH_TICKS = 3'd4;

    localparam logic [RUN_W-1:0]   ZERO_MIN_RESET        = 8'd7;
    localparam logic [RUN_W-1:0]   ONE_MIN_RESET         = 8'd9;
    localparam logic [RUN_W-1:0]   TOO_LONG_LIMIT_RESET  = 8'd17;
    localparam logic [TICKS_W-1:0] ONE_HIGH_TICKS_RESET  = 4'd8;
    localparam logic [TICKS_W-1:0] ZERO_HIGH_TICKS_RESET = 4'd4;

    localparam logic [RUN_W-1:0]   RUN_MAX = 8'd255;

    typedef enum logic [2:0] {
        TX_IDLE = 3'b001,
        TX_SEND = 3'b010,
        TX_END  = 3'b100
    } tx_phase_t;

    typedef struct packed {
        logic frame_done;
        logic pulse_error;
    } rx_status_t;

    typedef struct packed {
        logic line_level;
        logic busy;
    } tx_status_t;

endpackage

### rtl/core/pwfc_rx.sv
module pwfc_rx
    import pwfc_pkg::*;
#(
    parameter int FRAME_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  line_in,
    input  logic [RUN_W-1:0]      zero_min,
    input  logic [RUN_W-1:0]      one_min,
    input  logic [RUN_W-1:0]      too_long_limit,
    output rx_status_t            status,
    output logic [FRAME_BITS-1:0] frame
);

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(FRAME_BITS - 1);

    logic                  run_level_reg;
    logic                  run_level_next;
    logic [RUN_W-1:0]      run_len_reg;
    logic [RUN_W-1:0]      run_len_next;
    logic [FRAME_BITS-1:0] rx_shift_reg;
    logic [FRAME_BITS-1:0] rx_shift_next;
    logic [IDX_W-1:0]      rx_index_reg;
    logic [IDX_W-1:0]      rx_index_next;

    logic                  run_ends;
    logic                  bad_run;
    logic                  bit_value;
    logic [FRAME_BITS-1:0] shift_with_bit;

    always_comb
    begin
        run_ends  = (run_len_reg != '0) && run_level_reg && !line_in;
        bad_run   = (run_len_reg < zero_min)
                    || ((run_len_reg >= too_long_limit) && (run_len_reg >= one_min))
                    || ((run_len_reg >= one_min) && (run_len_reg >= too_long_limit));
        bit_value = (run_len_reg >= one_min);

        shift_with_bit               = rx_shift_reg;
        shift_with_bit[rx_index_reg] = rx_shift_reg[rx_index_reg] | bit_value;

        run_level_next = run_level_reg;
        run_len_next   = run_len_reg;
        rx_shift_next  = rx_shift_reg;
        rx_index_next  = rx_index_reg;
        status         = '0;
        frame          = '0;

        if (run_len_reg == '0)
        begin
            run_level_next = line_in;
            run_len_next   = RUN_W'(1);
        end
        else if (run_level_reg != line_in)
        begin
            run_level_next = 1'b0;
            run_len_next   = '0;
        end
        else if (run_len_reg != RUN_MAX)
        begin
            run_len_next = run_len_reg + RUN_W'(1);
        end

        if (run_ends)
        begin
            if (bad_run)
            begin
                status.pulse_error = 1'b1;
                rx_shift_next      = '0;
                rx_index_next      = IDX_TOP;
            end
            else if (rx_index_reg != '0)
            begin
                rx_shift_next = shift_with_bit;
                rx_index_next = rx_index_reg - IDX_W'(1);
            end
            else
            begin
                status.frame_done = 1'b1;
                frame             = shift_with_bit;
                rx_shift_next     = '0;
                rx_index_next     = IDX_TOP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_level_reg <= 1'b0;
            run_len_reg   <= '0;
            rx_shift_reg  <= '0;
            rx_index_reg  <= IDX_TOP;
        end
        else if (advance)
        begin
            run_level_reg <= run_level_next;
            run_len_reg   <= run_len_next;
            rx_shift_reg  <= rx_shift_next;
            rx_index_reg  <= rx_index_next;
        end
    end

endmodule

### rtl/core/pwfc_tx.sv
module pwfc_tx
    import pwfc_pkg::*;
#(
    parameter int ADDRESS_BITS = 7,
    parameter int DATA_BITS    = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    send_request,
    input  logic [ADDRESS_BITS-1:0] send_address,
    input  logic [DATA_BITS-1:0]    send_data,
    input  logic [TICKS_W-1:0]      one_high_ticks,
    input  logic [TICKS_W-1:0]      zero_high_ticks,
    output tx_status_t              status
);

    localparam int FRAME_BITS = 1 + ADDRESS_BITS + DATA_BITS;
    localparam int IDX_W      = $clog2(FRAME_BITS);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(FRAME_BITS - 1);

    tx_phase_t             phase_reg;
    tx_phase_t             phase_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [IDX_W-1:0]      index_reg;
    logic [IDX_W-1:0]      index_next;
    logic [TICKS_W-1:0]    ticks_left_reg;
    logic [TICKS_W-1:0]    ticks_left_next;
    logic                  toggle_reg;
    logic                  toggle_next;
    logic                  drive_reg;
    logic                  drive_next;

    logic                  start_send;
    logic [TICKS_W-1:0]    high_ticks;

    always_comb
    begin
        start_send = send_request && (phase_reg != TX_SEND) && (phase_reg != TX_END);

        phase_next      = phase_reg;
        frame_next      = frame_reg;
        index_next      = index_reg;
        ticks_left_next = ticks_left_reg;
        drive_next      = drive_reg;
        toggle_next     = ~toggle_reg;

        if (start_send)
        begin
            phase_next      = TX_SEND;
            frame_next      = {1'b1, send_address, send_data};
            index_next      = IDX_TOP;
            ticks_left_next = '0;
        end

        high_ticks = frame_next[index_next] ? one_high_ticks : zero_high_ticks;
        if (high_ticks == '0)
        begin
            high_ticks = TICKS_W'(1);
        end

        if (toggle_next)
        begin
            case (phase_next)
                TX_SEND:
                begin
                    if (ticks_left_next == '0)
                    begin
                        drive_next      = 1'b1;
                        ticks_left_next = high_ticks;
                    end
                    else
                    begin
                        if (ticks_left_next == TICKS_W'(1))
                        begin
                            drive_next = 1'b0;
                            if (index_next == '0)
                            begin
                                phase_next = TX_END;
                            end
                            else
                            begin
                                index_next = index_next - IDX_W'(1);
                            end
                        end
                        ticks_left_next = ticks_left_next - TICKS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = TX_IDLE;
                end
            endcase
        end

        status.line_level = drive_next;
        status.busy       = (phase_next == TX_SEND) || (phase_next == TX_END);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= TX_IDLE;
            frame_reg      <= '0;
            index_reg      <= '0;
            ticks_left_reg <= '0;
            toggle_reg     <= 1'b0;
            drive_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            frame_reg      <= frame_next;
            index_reg      <= index_next;
            ticks_left_reg <= ticks_left_next;
            toggle_reg     <= toggle_next;
            drive_reg      <= drive_next;
        end
    end

endmodule

### rtl/core/pulse_width_frame_transceiver.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      line_in, send_request, send_address, send_data
// out       output     out_valid / out_ready    line_out, tx_busy, frame_valid, frame_start,
//                                               frame_address, frame_data, pulse_error
// cfg       input      cfg_write_en             cfg_index, cfg_data
//
// One sample tick per cycle while in_ready is high; its result appears in the output register in the next cycle.
// in_ready is high whenever the output register is empty or is being drained.
// A stalled output holds its result and blocks only further ticks.
// Reset clears the receiver, the transmitter and loads the default thresholds.
module pulse_width_frame_transceiver
    import pwfc_pkg::*;
#(
    parameter int ADDRESS_BITS = 7,
    parameter int DATA_BITS    = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    line_in,
    input  logic                    send_request,
    input  logic [ADDRESS_BITS-1:0] send_address,
    input  logic [DATA_BITS-1:0]    send_data,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    line_out,
    output logic                    tx_busy,
    output logic                    frame_valid,
    output logic                    frame_start,
    output logic [ADDRESS_BITS-1:0] frame_address,
    output logic [DATA_BITS-1:0]    frame_data,
    output logic                    pulse_error
);

    localparam int FRAME_BITS = 1 + ADDRESS_BITS + DATA_BITS;

    logic [RUN_W-1:0]   zero_min_reg;
    logic [RUN_W-1:0]   one_min_reg;
    logic [RUN_W-1:0]   too_long_limit_reg;
    logic [TICKS_W-1:0] one_high_ticks_reg;
    logic [TICKS_W-1:0] zero_high_ticks_reg;

    logic                  accept;
    rx_status_t            rx_status;
    logic [FRAME_BITS-1:0] rx_frame;
    tx_status_t            tx_status;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    line_out_reg;
    logic                    tx_busy_reg;
    logic                    frame_valid_reg;
    logic                    pulse_error_reg;
    logic [FRAME_BITS-1:0]   frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_min_reg        <= ZERO_MIN_RESET;
            one_min_reg         <= ONE_MIN_RESET;
            too_long_limit_reg  <= TOO_LONG_LIMIT_RESET;
            one_high_ticks_reg  <= ONE_HIGH_TICKS_RESET;
            zero_high_ticks_reg <= ZERO_HIGH_TICKS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ZERO_MIN:        zero_min_reg        <= cfg_data;
                CFG_ONE_MIN:         one_min_reg         <= cfg_data;
                CFG_TOO_LONG_LIMIT:  too_long_limit_reg  <= cfg_data;
                CFG_ONE_HIGH_TICKS:  one_high_ticks_reg  <= cfg_data[TICKS_W-1:0];
                CFG_ZERO_HIGH_TICKS: zero_high_ticks_reg <= cfg_data[TICKS_W-1:0];
                default:             ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pwfc_rx #(
        .FRAME_BITS (FRAME_BITS)
    ) u_rx (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .line_in        (line_in),
        .zero_min       (zero_min_reg),
        .one_min        (one_min_reg),
        .too_long_limit (too_long_limit_reg),
        .status         (rx_status),
        .frame          (rx_frame)
    );

    pwfc_tx #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS)
    ) u_tx (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (accept),
        .send_request    (send_request),
        .send_address    (send_address),
        .send_data       (send_data),
        .one_high_ticks  (one_high_ticks_reg),
        .zero_high_ticks (zero_high_ticks_reg),
        .status          (tx_status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_out_reg    <= tx_status.line_level;
            tx_busy_reg     <= tx_status.busy;
            frame_valid_reg <= rx_status.frame_done;
            pulse_error_reg <= rx_status.pulse_error;
            frame_reg       <= rx_frame;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_out      = line_out_reg;
    assign tx_busy       = tx_busy_reg;
    assign frame_valid   = frame_valid_reg;
    assign pulse_error   = pulse_error_reg;
    assign frame_start   = frame_reg[FRAME_BITS-1];
    assign frame_address = frame_reg[FRAME_BITS-2:DATA_BITS];
    assign frame_data    = frame_reg[DATA_BITS-1:0];

endmodule

### rtl/core/pwfc_checker.sv
module pwfc_checker
    import pwfc_pkg::*;
#(
    parameter int ADDRESS_BITS = 7,
    parameter int DATA_BITS    = 2
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    line_out,
    input logic                    tx_busy,
    input logic                    frame_valid,
    input logic                    frame_start,
    input logic [ADDRESS_BITS-1:0] frame_address,
    input logic [DATA_BITS-1:0]    frame_data,
    input logic                    pulse_error
);

    // one run decode per tick: a frame and an error never coincide
    a_frame_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_valid && pulse_error))
        else $error("frame and pulse error in the same result");

    a_frame_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_valid) |->
            (frame_start == 1'b0 && frame_address == '0 && frame_data == '0))
        else $error("frame fields nonzero without a frame");

    a_high_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_out) |-> tx_busy)
        else $error("line driven high while transmitter idle");

    a_empty_takes_request: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(line_out) && $stable(tx_busy) && $stable(frame_valid)))
        else $error("stalled result changed");

endmodule

bind pulse_width_frame_transceiver pwfc_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS)
) u_pwfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_out      (line_out),
    .tx_busy       (tx_busy),
    .frame_valid   (frame_valid),
    .frame_start   (frame_start),
    .frame_address (frame_address),
    .frame_data    (frame_data),
    .pulse_error   (pulse_error)
);
